/* rtl/wsm_pkg.sv */
// Shared types, constants and helpers of the word substring matcher.
`timescale 1ns / 1ps

package wsm_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int PATTERN_SLOTS = 16;
   localparam int LEN_LIMIT     = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;
   localparam int HISTORY_DEPTH = PATTERN_SLOTS - 1;
   localparam int LEN_W         = 5;
   localparam int COUNT_W       = 5;
   localparam int TOTAL_W       = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [LEN_W-1:0]   LEN_CLAMP = LEN_W'(LEN_LIMIT);

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LO  = 2'd0,
      CSR_PATTERN_HI  = 2'd1,
      CSR_PATTERN_LEN = 2'd2,
      CSR_CASE_FOLD   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       word_end;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic               match_flag;
      logic [TOTAL_W-1:0] matched_total;
   } rsp_type;

   typedef struct packed {
      logic [PATTERN_SLOTS-1:0][7:0] pattern;
      logic [LEN_W-1:0]              pattern_length;
      logic                          case_fold;
   } cfg_type;

   typedef logic [HISTORY_DEPTH-1:0][7:0] history_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ignore);
      logic [7:0] r;
      r = c;
      if (ignore && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
         r = c + ASCII_CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

/* rtl/wsm_cfg_regs.sv */
// Configuration register file of the word substring matcher.
`timescale 1ns / 1ps

module wsm_cfg_regs import wsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LO:  cfg_in.pattern[7:0]    = csr_write_data;
            CSR_PATTERN_HI:  cfg_in.pattern[15:8]   = csr_write_data;
            CSR_PATTERN_LEN: cfg_in.pattern_length  = csr_write_data[LEN_W-1:0];
            CSR_CASE_FOLD:   cfg_in.case_fold       = csr_write_data[0];
            default:         cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/wsm_compare.sv */
// Parallel comparison of the newest bytes of a word against the pattern.
`timescale 1ns / 1ps

module wsm_compare import wsm_pkg::*; (
   input  logic [7:0]         char_byte,
   input  history_type        history,
   input  logic [COUNT_W-1:0] bytes_in_word,
   input  cfg_type            cfg,
   output logic               hit
);

   logic [LEN_W-1:0]              len;
   logic [PATTERN_SLOTS-1:0][7:0] window;
   logic [PATTERN_SLOTS-1:0]      pos_ok;
   logic [LEN_W-1:0]              offset [PATTERN_SLOTS];

   // Pattern character i lines up with the byte that is len-1-i positions back.
   always_comb begin
      len = (cfg.pattern_length > LEN_CLAMP) ? LEN_CLAMP : cfg.pattern_length;
      window[0] = char_byte;
      for (int k = 1; k < PATTERN_SLOTS; k++) begin
         window[k] = history[k-1];
      end
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
         offset[i] = len - LEN_W'(i) - LEN_W'(1);
         if (LEN_W'(i) < len) begin
            pos_ok[i] = fold_char(window[offset[i][3:0]], cfg.case_fold)
                        == fold_char(cfg.pattern[i], cfg.case_fold);
         end else begin
            pos_ok[i] = 1'b1;
         end
      end
      if (len == '0) begin
         hit = 1'b1;
      end else begin
         hit = (bytes_in_word >= (len - LEN_W'(1))) && (&pos_ok);
      end
   end

endmodule

/* rtl/word_substring_matcher.sv */
// Top level of the word substring matcher: input stage, word state and result register.
`timescale 1ns / 1ps

//  channel | ports                                   | direction | beat
//  --------+-----------------------------------------+-----------+------------------------------
//  req     | req_valid, req_ready, req_payload       | in        | one byte, end-of-word mark
//  rsp     | rsp_valid, rsp_ready, rsp_payload       | out       | match flag, matching total
//  csr     | csr_write_enable, csr_index, csr_write_data | in    | register write, no wait
//
// A request beat waits in the input register while the comparator bank checks it; when it
// advances it moves into the word state and, for the last byte of a word, loads the response
// register, so rsp_valid rises after that byte has passed the input and response registers.
// One beat is accepted per cycle for as long as responses are taken.
// The response register is the only place a stall holds work: while it is full and not
// taken, a held end-of-word beat in the input register stops further requests.
// Synchronous active-high reset clears the pipeline, word state, count and registers.
// Configuration is expected to change only while no beat is in flight.

module word_substring_matcher import wsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg;

   wsm_cfg_regs u_cfg_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Input register.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_beat_ff,  s1_beat_in;

   // Word state.
   history_type        history_ff, history_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic               hit_seen_ff, hit_seen_in;
   logic [TOTAL_W-1:0] total_ff,   total_in;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_beat_ff,  rsp_beat_in;

   logic hit_now;
   logic word_hit;
   logic s1_advance;
   logic req_take;

   wsm_compare u_compare (
      .char_byte     (s1_beat_ff.char_byte),
      .history       (history_ff),
      .bytes_in_word (count_ff),
      .cfg           (cfg),
      .hit           (hit_now)
   );

   // A byte without an end mark always retires; an end byte needs room for its response.
   assign s1_advance = s1_valid_ff &&
                       (!s1_beat_ff.word_end || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;
   assign word_hit   = hit_seen_ff || hit_now;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_beat_in   = s1_beat_ff;
      history_in   = history_ff;
      count_in     = count_ff;
      hit_seen_in  = hit_seen_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_advance) begin
         s1_valid_in = 1'b0;
         history_in  = {history_ff[HISTORY_DEPTH-2:0], s1_beat_ff.char_byte};
         if (s1_beat_ff.word_end) begin
            if (word_hit && (total_ff != TOTAL_MAX)) begin
               total_in = total_ff + TOTAL_W'(1);
            end
            rsp_valid_in              = 1'b1;
            rsp_beat_in.match_flag    = word_hit;
            rsp_beat_in.matched_total = (word_hit && (total_ff != TOTAL_MAX)) ?
                                        total_ff + TOTAL_W'(1) : total_ff;
            hit_seen_in = 1'b0;
            count_in    = '0;
         end else begin
            hit_seen_in = word_hit;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end

      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_beat_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         history_ff   <= '0;
         count_ff     <= '0;
         hit_seen_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         history_ff   <= history_in;
         count_ff     <= count_in;
         hit_seen_ff  <= hit_seen_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff  <= s1_beat_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_beat_ff;

endmodule

/* rtl/wsm_checker.sv */
// Port-level checks of the word substring matcher, bound to the top level.
`timescale 1ns / 1ps

module wsm_checker import wsm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A waiting response keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // A new response follows an accepted end-of-word beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_payload.word_end, 2))
      else $error("response without an end-of-word request");

   // A matching word is always counted, and the count never wraps to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.match_flag |-> rsp_payload.matched_total != '0)
      else $error("matching word with a zero total");

   // Reset leaves no response pending.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind word_substring_matcher wsm_checker u_wsm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* tb/tb_top.sv */
// Self-checking testbench for the word substring matcher, with its own prediction of each word.
`timescale 1ns / 1ps

// The bench drives bytes into the request channel and predicts every response beat
// from a local copy of the word state and the pattern registers. Prediction happens at
// the edge that accepts a request beat. A monitor compares each accepted response beat,
// field by field, with the oldest pending verdict. Both channels insert random gaps
// before their beats. Some phases run with no gaps at all, so the pipeline also sees
// back-to-back traffic. The pattern registers change only while no beat is in flight.

module tb_top;
   import wsm_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RANDOM_BEATS  = 1150;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_write_enable = 1'b0;
   csr_index_type     csr_index = CSR_PATTERN_LO;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // Local copy of the pattern registers, updated when a register set is written.
   logic [63:0]       pattern_lo_copy = '0;
   logic [63:0]       pattern_hi_copy = '0;
   logic [LEN_W-1:0]  pattern_len_copy = '0;
   logic              fold_copy = 1'b0;

   // Local copy of the word state: recent bytes (entry 0 newest), bytes seen in the
   // current word (saturating), the sticky hit and the saturating matching-word total.
   logic [7:0]        recent_bytes [HISTORY_DEPTH];
   logic [COUNT_W-1:0] word_bytes_seen = '0;
   logic              word_hit = 1'b0;
   logic [TOTAL_W-1:0] words_matched = '0;

   rsp_type           pending_verdicts [$];

   bit                steady_flow = 1'b0;
   int                fail_count = 0;
   int                beats_sent = 0;
   int                words_checked = 0;
   int                settings_used = 0;
   int                cycle_count = 0;

   word_substring_matcher u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   initial begin
      foreach (recent_bytes[i]) begin
         recent_bytes[i] = 8'h00;
      end
   end

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   // ASCII fold of one byte as the matcher applies it when case folding is enabled.
   function automatic logic [7:0] casefold(input logic [7:0] c);
      if (fold_copy && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Raw pattern character i, first character in the low byte of the low register.
   function automatic logic [7:0] pattern_raw(input int i);
      logic [127:0] chars;
      chars = {pattern_hi_copy, pattern_lo_copy};
      return chars[i*8 +: 8];
   endfunction

   // Pattern lengths beyond the comparator capacity are clamped.
   function automatic int pattern_span();
      return (int'(pattern_len_copy) > LEN_LIMIT) ? LEN_LIMIT : int'(pattern_len_copy);
   endfunction

   // Advances the word state by one accepted beat and queues the verdict of a finished
   // word. The newest byte is compared with the last pattern character and the history
   // with the earlier ones, but only once the word holds enough bytes, so bytes left
   // over from the previous word never take part.
   function automatic void predict_beat(input req_type b);
      rsp_type verdict;
      int      span;
      bit      same;
      span = pattern_span();
      if (span == 0) begin
         word_hit = 1'b1;
      end else if (int'(word_bytes_seen) >= span - 1) begin
         same = (casefold(b.char_byte) == casefold(pattern_raw(span - 1)));
         for (int k = 1; k < span; k++) begin
            if (casefold(recent_bytes[k-1]) != casefold(pattern_raw(span - 1 - k))) begin
               same = 1'b0;
            end
         end
         if (same) begin
            word_hit = 1'b1;
         end
      end
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
         recent_bytes[k] = recent_bytes[k-1];
      end
      recent_bytes[0] = b.char_byte;
      if (word_bytes_seen != '1) begin
         word_bytes_seen = word_bytes_seen + 1'b1;
      end
      if (b.word_end) begin
         if (word_hit && words_matched != '1) begin
            words_matched = words_matched + 1'b1;
         end
         verdict.match_flag    = word_hit;
         verdict.matched_total = words_matched;
         pending_verdicts.push_back(verdict);
         word_hit        = 1'b0;
         word_bytes_seen = '0;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Sends one beat after a random gap. Valid stays high without a dip when the next
   // beat follows with no gap, and the beat is predicted at the edge that accepts it.
   task automatic send_beat(input logic [7:0] c, input logic last);
      req_type b;
      int      gap;
      b.char_byte = c;
      b.word_end  = last;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (!req_ready);
      predict_beat(b);
      beats_sent++;
   endtask

   task automatic send_text(input string s, input bit close_word);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(s[i], close_word && (i == s.len() - 1));
      end
   endtask

   // Stops the request stream and waits until every verdict has arrived. Bytes without
   // an end mark cause no response, so a further settling wait lets the last of them retire.
   task automatic drain_matcher();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four pattern registers, one per edge, once the matcher is idle.
   task automatic program_matcher(input logic [127:0] chars, input int len, input bit fold);
      drain_matcher();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PATTERN_LO;
      csr_write_data   <= chars[63:0];
      @(posedge clock);
      csr_index        <= CSR_PATTERN_HI;
      csr_write_data   <= chars[127:64];
      @(posedge clock);
      csr_index        <= CSR_PATTERN_LEN;
      csr_write_data   <= CSR_DATA_W'(len[LEN_W-1:0]);
      @(posedge clock);
      csr_index        <= CSR_CASE_FOLD;
      csr_write_data   <= CSR_DATA_W'(fold);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pattern_lo_copy  = chars[63:0];
      pattern_hi_copy  = chars[127:64];
      pattern_len_copy = len[LEN_W-1:0];
      fold_copy        = fold;
      settings_used++;
      @(posedge clock);
   endtask

   function automatic logic [127:0] pack_text(input string s);
      logic [127:0] chars;
      chars = '0;
      for (int i = 0; i < s.len() && i < 16; i++) begin
         chars[i*8 +: 8] = s[i];
      end
      return chars;
   endfunction

   // ---------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------

   // Ready may drop for a random gap before each response beat; phases without gaps keep it high.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = steady_flow ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response beat with no word pending: match_flag %0d matched_total %0d",
                   rsp_payload.match_flag, rsp_payload.matched_total);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            words_checked++;
            if (rsp_payload.match_flag !== want.match_flag) begin
               $error("match_flag: expected %0d, actual %0d",
                      want.match_flag, rsp_payload.match_flag);
               fail_count++;
            end
            if (rsp_payload.matched_total !== want.matched_total) begin
               $error("matched_total: expected %0d, actual %0d",
                      want.matched_total, rsp_payload.matched_total);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d words pending",
                  cycle_count, pending_verdicts.size());
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Out of reset the pattern is empty, so every word matches, including words made of
   // the lowest and the highest byte value.
   task automatic test_empty_pattern_after_reset();
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
   endtask

   // Folding makes "AbC" match any mix of cases, and without it only the exact case
   // hits. The bytes just outside the upper-case range must never be folded.
   task automatic test_case_folding();
      program_matcher(pack_text("AbC"), 3, 1'b1);
      send_text("xaBc", 1'b1);
      program_matcher(pack_text("`{"), 2, 1'b1);
      send_text("@[", 1'b1);
      program_matcher(pack_text("AbC"), 3, 1'b0);
      send_text("AbC", 1'b1);
      send_text("abc", 1'b1);
   endtask

   // A pattern split across the end of one word and the start of the next is no hit,
   // and a word shorter than the pattern cannot hit either.
   task automatic test_word_boundaries();
      program_matcher(pack_text("ab"), 2, 1'b0);
      send_text("xa", 1'b1);
      send_text("b", 1'b1);
   endtask

   // A pattern change in the middle of a word applies to the bytes that follow it.
   task automatic test_config_mid_word();
      send_text("a", 1'b0);
      program_matcher(pack_text("qb"), 2, 1'b0);
      send_text("b", 1'b1);
   endtask

   function automatic logic [7:0] flip_case_maybe(input logic [7:0] c);
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
          $urandom_range(0, 1) == 1) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   // Filler is mostly made of pattern characters, so near misses are common.
   function automatic logic [7:0] filler_byte();
      int span;
      span = pattern_span();
      if (span > 0 && $urandom_range(0, 9) < 7) begin
         return flip_case_maybe(pattern_raw($urandom_range(0, span - 1)));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Pattern styles: 0 letters of mixed case, 1 any byte, 2 all zero, 3 all ones.
   function automatic logic [127:0] make_pattern(input int style);
      logic [127:0] chars;
      for (int i = 0; i < 16; i++) begin
         case (style)
            0: chars[i*8 +: 8] = 8'($urandom_range(0, 25)) +
                                 (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61);
            1: chars[i*8 +: 8] = 8'($urandom_range(0, 255));
            2: chars[i*8 +: 8] = 8'h00;
            default: chars[i*8 +: 8] = 8'hFF;
         endcase
      end
      return chars;
   endfunction

   // Most words embed a copy of the pattern, sometimes cut short or with one byte
   // spoiled, between runs of filler. Others are pure noise or long enough to saturate
   // the per-word byte count.
   task automatic send_random_word();
      logic [7:0] text [$];
      int         span;
      int         roll;
      int         cut;
      int         pre;
      int         post;
      int         n;
      span = pattern_span();
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
         n = $urandom_range(1, 12);
         repeat (n) text.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 3) begin
         n = $urandom_range(32, 40);
         repeat (n) text.push_back(filler_byte());
      end else begin
         pre  = $urandom_range(0, 6);
         post = $urandom_range(0, 6);
         repeat (pre) text.push_back(filler_byte());
         if (span > 0) begin
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
            for (int i = 0; i < cut; i++) begin
               text.push_back(flip_case_maybe(pattern_raw(i)));
            end
            if ($urandom_range(0, 4) == 0) begin
               text[$urandom_range(pre, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end
         repeat (post) text.push_back(filler_byte());
         if (text.size() == 0) begin
            text.push_back(filler_byte());
         end
      end
      foreach (text[i]) begin
         send_beat(text[i], i == text.size() - 1);
      end
   endtask

   // Random phases, each under its own pattern setting. The first phases pin the
   // extremes: the full 16 characters, a length above capacity, an empty pattern, and
   // patterns of all ones and all zeros. About one phase in three leaves its last word
   // open, so the next setting takes over in the middle of that word.
   task automatic test_random_words();
      int goal;
      int phase_goal;
      int phase;
      int style;
      int len;
      phase = 0;
      goal  = beats_sent + RANDOM_BEATS;
      while (beats_sent < goal) begin
         case (phase)
            0: begin style = 1; len = 16; end
            1: begin style = 0; len = 31; end
            2: begin style = 1; len = 0; end
            3: begin style = 3; len = 16; end
            4: begin style = 2; len = 16; end
            default: begin
               style = $urandom_range(0, 1);
               len   = $urandom_range(1, 20);
            end
         endcase
         program_matcher(make_pattern(style), len, $urandom_range(0, 1));
         steady_flow = ($urandom_range(0, 3) == 0);
         phase_goal  = beats_sent + 90;
         while (beats_sent < phase_goal) begin
            send_random_word();
         end
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) send_beat(filler_byte(), 1'b0);
         end
         phase++;
      end
      send_beat(filler_byte(), 1'b1);
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_pattern_after_reset();
      test_case_folding();
      test_word_boundaries();
      test_config_mid_word();
      test_random_words();

      drain_matcher();
      if (pending_verdicts.size() != 0) begin
         $error("%0d words never got a response", pending_verdicts.size());
         fail_count++;
      end

      $display("Covered %0d request beats and %0d finished words under %0d pattern settings.",
               beats_sent, words_checked, settings_used);
      $display("Settings included empty, full and over-long patterns, with and without folding.");
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/wsm_pkg.sv
rtl/wsm_cfg_regs.sv
rtl/wsm_compare.sv
rtl/word_substring_matcher.sv
rtl/wsm_checker.sv
tb/tb_top.sv
